// ===== rtl/fgc_pkg.sv =====
package fgc_pkg;

  // Cipher geometry
  localparam int unsigned WORD_W     = 32;
  localparam int unsigned NUM_ROUNDS = 32;
  localparam int unsigned NUM_KEYS   = 8;
  localparam int unsigned KEY_IDX_W  = 3;
  localparam int unsigned NIB_W      = 4;
  localparam int unsigned NUM_NIBS   = WORD_W / NIB_W;
  localparam int unsigned ROT_L      = 11;
  // Key order runs forward for this many 8-round passes on encrypt
  localparam int unsigned ENC_FWD_PASSES = 3;
  localparam int unsigned DEC_FWD_PASSES = 1;

  typedef logic [WORD_W-1:0]                word_t;
  typedef logic [KEY_IDX_W-1:0]             key_idx_t;
  typedef logic [NIB_W-1:0]                 nib_t;
  typedef logic [NUM_KEYS-1:0][WORD_W-1:0]  key_bank_t;

  // One block in flight through the round pipeline
  typedef struct packed {
    logic  vld;
    logic  dec;
    word_t left;
    word_t right;
  } blk_t;

  // Substitution table: row n serves nibble n of the sum
  localparam nib_t SBOX [NUM_NIBS][16] = '{
    '{4'h0, 4'h1, 4'h2, 4'h3, 4'h4, 4'h5, 4'h6, 4'h7,
      4'h8, 4'h9, 4'hA, 4'hB, 4'hC, 4'hD, 4'hE, 4'hF},
    '{4'hF, 4'hE, 4'hD, 4'hC, 4'hB, 4'hA, 4'h9, 4'h8,
      4'h7, 4'h6, 4'h5, 4'h4, 4'h3, 4'h2, 4'h1, 4'h0},
    '{4'h0, 4'h8, 4'h1, 4'h9, 4'h2, 4'hA, 4'h3, 4'hB,
      4'h4, 4'hC, 4'h5, 4'hD, 4'h6, 4'hE, 4'h7, 4'hF},
    '{4'h0, 4'h1, 4'h2, 4'h3, 4'h4, 4'h5, 4'h6, 4'h7,
      4'hF, 4'hE, 4'hD, 4'hC, 4'hB, 4'hA, 4'h9, 4'h8},
    '{4'hF, 4'hE, 4'hD, 4'hC, 4'hB, 4'hA, 4'h9, 4'h8,
      4'h0, 4'h1, 4'h2, 4'h3, 4'h4, 4'h5, 4'h6, 4'h7},
    '{4'h1, 4'h3, 4'h5, 4'h7, 4'h9, 4'hB, 4'hD, 4'hF,
      4'h0, 4'h2, 4'h4, 4'h6, 4'h8, 4'hA, 4'hC, 4'hE},
    '{4'h6, 4'hA, 4'h0, 4'h4, 4'hB, 4'h1, 4'h5, 4'h9,
      4'hC, 4'h3, 4'h7, 4'hE, 4'h2, 4'h8, 4'hD, 4'hF},
    '{4'h0, 4'h1, 4'h9, 4'h2, 4'h8, 4'h3, 4'h7, 4'h4,
      4'h6, 4'h5, 4'hA, 4'hF, 4'hB, 4'hE, 4'hC, 4'hD}
  };

  // Key word used by a given round; evaluated at elaboration only
  function automatic key_idx_t round_key_idx(input int unsigned rnd, input logic dec);
    int unsigned pass_n;
    int unsigned pos;
    logic        fwd;
    pass_n = rnd >> KEY_IDX_W;
    pos    = rnd & (NUM_KEYS - 1);
    fwd    = dec ? (pass_n < DEC_FWD_PASSES) : (pass_n < ENC_FWD_PASSES);
    return fwd ? key_idx_t'(pos) : key_idx_t'(NUM_KEYS - 1 - pos);
  endfunction

  // Round function: add key, substitute nibbles, rotate left
  function automatic word_t round_fn(input word_t half, input word_t key);
    word_t sum;
    word_t sub;
    sum = half + key;
    for (int i = 0; i < NUM_NIBS; i++) begin
      sub[i*NIB_W +: NIB_W] = SBOX[i][sum[i*NIB_W +: NIB_W]];
    end
    return {sub[WORD_W-ROT_L-1:0], sub[WORD_W-1:WORD_W-ROT_L]};
  endfunction

endpackage

// ===== rtl/fgc_keys.sv =====
module fgc_keys (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  fgc_pkg::key_idx_t            cfg_idx_i,
  input  fgc_pkg::word_t               cfg_wdata_i,
  output fgc_pkg::key_bank_t           keys_o
);
  import fgc_pkg::*;

  key_bank_t key_q, key_d;

  // Write decode
  always_comb begin
    key_d = key_q;
    if (cfg_we_i) begin
      key_d[cfg_idx_i] = cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q <= '0;
    end else begin
      key_q <= key_d;
    end
  end

  assign keys_o = key_q;

  // A write lands in the addressed key word
  a_key_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i |=> key_q[$past(cfg_idx_i)] == $past(cfg_wdata_i))
    else $error("key word not updated by write");

  // Without a write the bank holds
  a_key_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !cfg_we_i |=> $stable(key_q))
    else $error("key bank changed without write");

endmodule

// ===== rtl/fgc_round.sv =====
module fgc_round (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  fgc_pkg::blk_t    stage_i,
  input  fgc_pkg::word_t   key_i,
  output fgc_pkg::blk_t    stage_o
);
  import fgc_pkg::*;

  logic  vld_q;
  logic  dec_q;
  word_t left_q, left_d;
  word_t right_q, right_d;

  // One Feistel round, halves swapped
  always_comb begin
    left_d  = stage_i.right;
    right_d = round_fn(stage_i.right, key_i) ^ stage_i.left;
  end

  // Valid bit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= stage_i.vld;
    end
  end

  // Payload, no reset
  always_ff @(posedge clk_i) begin
    dec_q   <= stage_i.dec;
    left_q  <= left_d;
    right_q <= right_d;
  end

  assign stage_o = '{vld: vld_q, dec: dec_q, left: left_q, right: right_q};

endmodule

// ===== rtl/feistel_64bit_block_cipher_unit.sv =====
// A block accepted at a clock edge passes through one register stage per round (32 rounds)
//   and raises done_o as it leaves the last stage, where the result is taken.
// Throughput: one block per cycle; busy_o stays low and start_i is always taken.
// The result is presented for one cycle only; the receiver cannot stall.
// Reset: asynchronous, active low; clears all stage valid bits and the key words to 0.
module feistel_64bit_block_cipher_unit (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // configuration write port
  input  logic                   cfg_we_i,
  input  fgc_pkg::key_idx_t      cfg_idx_i,
  input  fgc_pkg::word_t         cfg_wdata_i,
  // command side
  input  logic                   start_i,
  output logic                   busy_o,
  input  logic                   action_i,
  input  fgc_pkg::word_t         left_half_in_i,
  input  fgc_pkg::word_t         right_half_in_i,
  // result side
  output logic                   done_o,
  output fgc_pkg::word_t         left_half_out_o,
  output fgc_pkg::word_t         right_half_out_o
);
  import fgc_pkg::*;

  key_bank_t keys;
  blk_t      stage_in  [NUM_ROUNDS];
  blk_t      stage_out [NUM_ROUNDS];
  word_t     rkey      [NUM_ROUNDS];

  // Key registers
  fgc_keys u_keys (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .keys_o      (keys)
  );

  // Fully pipelined, never busy
  assign busy_o = 1'b0;

  // Pipeline entry
  assign stage_in[0] = '{vld: start_i & ~busy_o, dec: action_i,
                         left: left_half_in_i, right: right_half_in_i};

  // Round stages with a fixed key schedule per stage
  for (genvar k = 0; k < NUM_ROUNDS; k++) begin : g_round
    localparam key_idx_t ENC_IDX = round_key_idx(k, 1'b0);
    localparam key_idx_t DEC_IDX = round_key_idx(k, 1'b1);

    if (k > 0) begin : g_chain
      assign stage_in[k] = stage_out[k-1];
    end

    assign rkey[k] = stage_in[k].dec ? keys[DEC_IDX] : keys[ENC_IDX];

    fgc_round u_round (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .stage_i (stage_in[k]),
      .key_i   (rkey[k]),
      .stage_o (stage_out[k])
    );
  end

  // Output: undo the last swap
  assign done_o           = stage_out[NUM_ROUNDS-1].vld;
  assign left_half_out_o  = stage_out[NUM_ROUNDS-1].right;
  assign right_half_out_o = stage_out[NUM_ROUNDS-1].left;

  // Every result traces back to a start one latency earlier
  a_done_from_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i, NUM_ROUNDS))
    else $error("result without matching start");

  // Direction flag travels with its block
  a_dir_tracks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> stage_out[NUM_ROUNDS-1].dec == $past(action_i, NUM_ROUNDS))
    else $error("direction flag mismatch at output");

  // A valid block moves one stage per cycle, never dropped
  for (genvar k = 0; k < NUM_ROUNDS - 1; k++) begin : g_chk
    a_vld_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
      stage_out[k].vld |=> stage_out[k+1].vld)
      else $error("transaction dropped in pipeline");
  end

endmodule
